FILE: hdl/job_slot_table_assert.svh
// Assertion macros for the job slot table.
// JST_ASSERT checks at every clock edge outside of reset.
// JST_ASSERT_ALWAYS checks at every clock edge, reset included.
`ifndef JOB_SLOT_TABLE_ASSERT_SVH
`define JOB_SLOT_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define JST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("job_slot_table: assertion failed");
`define JST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("job_slot_table: assertion failed");
`else
`define JST_ASSERT(lbl, clk, rstn, prop)
`define JST_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/jst_pkg.sv
`default_nettype none

package jst_pkg;

  localparam int unsigned PROC_BITS = 22;
  localparam int unsigned JOB_BITS  = 16;
  localparam int unsigned MAXJOBS   = 16;

  // run states
  localparam logic [1:0] UNDEF = 2'd0;
  localparam logic [1:0] FG    = 2'd1;

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_DELETE    = 3'd1,
    REQ_FIND_PROC = 3'd2,
    REQ_FIND_JOB  = 3'd3,
    REQ_SET_STATE = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADKEY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_APPLY,
    S_SCAN2,
    S_RESP
  } seq_e;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [PROC_BITS-1:0] proc_id;
    logic [JOB_BITS-1:0]  job_id;
    logic [1:0]           new_state;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [JOB_BITS-1:0]  found_job_id;
    logic [PROC_BITS-1:0] found_proc_id;
    logic [1:0]           found_state;
    logic [PROC_BITS-1:0] foreground_proc;
  } out_item_t;

  typedef struct packed {
    logic [PROC_BITS-1:0] proc;
    logic [JOB_BITS-1:0]  job;
    logic [1:0]           state;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/jst_mem.sv
`default_nettype none

module jst_mem #(
  parameter int unsigned TABLE_ENTRIES = jst_pkg::MAXJOBS,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [AW-1:0]   rd_addr_i,
  output jst_pkg::entry_t      rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  jst_pkg::entry_t      wr_data_i
);
  import jst_pkg::*;

  entry_t                   mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  entry_t                   rd_ent_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_ent_q <= mem_q[rd_addr_i];
  end

  // an entry never written reads as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_ent_q : '0;

endmodule

`default_nettype wire

FILE: hdl/jst_ctrl.sv
`default_nettype none

module jst_ctrl #(
  parameter int unsigned TABLE_ENTRIES = jst_pkg::MAXJOBS,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  jst_pkg::in_item_t  in_item_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output jst_pkg::out_item_t res_item_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  jst_pkg::entry_t    mem_rdata_i,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output jst_pkg::entry_t    mem_wdata_o
);
  import jst_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  seq_e                 state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [JOB_BITS-1:0]  next_job_q, next_job_d;
  logic                 hit_q, hit_d;
  logic                 fg_found_q, fg_found_d;
  logic                 renum_q, renum_d;
  in_item_t             req_q, req_d;
  logic [AW-1:0]        hit_idx_q, hit_idx_d;
  entry_t               hit_ent_q, hit_ent_d;
  logic [PROC_BITS-1:0] fg_proc_q, fg_proc_d;
  logic [JOB_BITS-1:0]  max_job_q, max_job_d;
  out_item_t            res_q, res_d;

  logic [CW-1:0]        prev_cnt;
  logic [AW-1:0]        rd_idx;
  logic                 last;
  logic                 match;
  logic                 key_bad;
  logic [JOB_BITS:0]    nj_inc;
  logic [JOB_BITS-1:0]  nj_wrap;
  logic [JOB_BITS-1:0]  nj_renum;

  assign prev_cnt    = cnt_q - CW'(1);
  assign rd_idx      = prev_cnt[AW-1:0];
  assign last        = (cnt_q == CW'(TABLE_ENTRIES));
  assign mem_raddr_o = (cnt_q < CW'(TABLE_ENTRIES)) ? cnt_q[AW-1:0] : '0;

  assign key_bad = (req_q.req_type == REQ_FIND_JOB) ? (req_q.job_id == '0)
                                                    : (req_q.proc_id == '0);

  assign nj_inc  = (JOB_BITS+1)'(next_job_q) + (JOB_BITS+1)'(1);
  assign nj_wrap = ((nj_inc > (JOB_BITS+1)'(TABLE_ENTRIES)) ||
                    (nj_inc[JOB_BITS-1:0] == '0)) ? JOB_BITS'(1) : nj_inc[JOB_BITS-1:0];
  assign nj_renum = ((max_job_q + JOB_BITS'(1)) == '0) ? JOB_BITS'(1)
                                                       : max_job_q + JOB_BITS'(1);

  always_comb begin
    case (req_q.req_type) inside
      REQ_INSERT:   match = (mem_rdata_i.proc == '0);
      REQ_FIND_JOB: match = (mem_rdata_i.job == req_q.job_id);
      default:      match = (mem_rdata_i.proc == req_q.proc_id);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    next_job_d  = next_job_q;
    hit_d       = hit_q;
    fg_found_d  = fg_found_q;
    renum_d     = renum_q;
    req_d       = req_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    fg_proc_d   = fg_proc_q;
    max_job_d   = max_job_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = hit_idx_q;
    mem_wdata_o = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_item_i;
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cnt_d = cnt_q + CW'(1);
        // data of the address issued last cycle
        if (cnt_q != '0 && !hit_q && match) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx;
          hit_ent_d = mem_rdata_i;
        end
        if (last) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cnt_d      = '0;
        fg_found_d = 1'b0;
        fg_proc_d  = '0;
        max_job_d  = '0;
        renum_d    = 1'b0;
        res_d      = '0;
        res_d.status = ST_NONE;
        state_d    = S_SCAN2;
        unique case (req_q.req_type) inside
          REQ_INSERT: begin
            if (key_bad) begin
              res_d.status = ST_BADKEY;
            end else if (!hit_q) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we_o          = 1'b1;
              mem_wdata_o.proc  = req_q.proc_id;
              mem_wdata_o.job   = next_job_q;
              mem_wdata_o.state = req_q.new_state;
              res_d.status        = ST_OK;
              res_d.found_proc_id = req_q.proc_id;
              res_d.found_job_id  = next_job_q;
              res_d.found_state   = req_q.new_state;
              next_job_d          = nj_wrap;
            end
          end
          REQ_DELETE: begin
            if (key_bad) begin
              res_d.status = ST_BADKEY;
            end else if (hit_q) begin
              mem_we_o            = 1'b1;
              mem_wdata_o         = '0;
              res_d.status        = ST_OK;
              res_d.found_proc_id = hit_ent_q.proc;
              res_d.found_job_id  = hit_ent_q.job;
              res_d.found_state   = hit_ent_q.state;
              renum_d             = 1'b1;
            end
          end
          REQ_FIND_PROC, REQ_FIND_JOB: begin
            if (key_bad) begin
              res_d.status = ST_BADKEY;
            end else if (hit_q) begin
              res_d.status        = ST_OK;
              res_d.found_proc_id = hit_ent_q.proc;
              res_d.found_job_id  = hit_ent_q.job;
              res_d.found_state   = hit_ent_q.state;
            end
          end
          REQ_SET_STATE: begin
            if (key_bad) begin
              res_d.status = ST_BADKEY;
            end else if (hit_q) begin
              mem_we_o            = 1'b1;
              mem_wdata_o.proc    = hit_ent_q.proc;
              mem_wdata_o.job     = hit_ent_q.job;
              mem_wdata_o.state   = req_q.new_state;
              res_d.status        = ST_OK;
              res_d.found_proc_id = hit_ent_q.proc;
              res_d.found_job_id  = hit_ent_q.job;
              res_d.found_state   = req_q.new_state;
            end
          end
          default: begin
            res_d.status = ST_NONE;
          end
        endcase
      end
      S_SCAN2: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0) begin
          if (!fg_found_q && mem_rdata_i.state == FG) begin
            fg_found_d = 1'b1;
            fg_proc_d  = mem_rdata_i.proc;
          end
          if (mem_rdata_i.job > max_job_q) begin
            max_job_d = mem_rdata_i.job;
          end
        end
        if (last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (renum_q) begin
            next_job_d = nj_renum;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_item_o                 = res_q;
    res_item_o.foreground_proc = fg_proc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      next_job_q <= JOB_BITS'(1);
      hit_q      <= 1'b0;
      fg_found_q <= 1'b0;
      renum_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      next_job_q <= next_job_d;
      hit_q      <= hit_d;
      fg_found_q <= fg_found_d;
      renum_q    <= renum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    hit_idx_q <= hit_idx_d;
    hit_ent_q <= hit_ent_d;
    fg_proc_q <= fg_proc_d;
    max_job_q <= max_job_d;
    res_q     <= res_d;
  end

endmodule

`default_nettype wire

FILE: hdl/job_slot_table.sv
`default_nettype none
// Job slot table: TABLE_ENTRIES process entries (process id, job id, run
// state) in one single-port-read, single-port-write RAM with registered read
// data. Each item is handled on its own: a first pass over the RAM finds the
// slot, an apply step writes it back if the request changes it, a second
// pass finds the first foreground entry and the largest job id, and the
// result then goes to the output register. Each pass reads one entry per
// cycle. The next item is taken in the cycle after the result has moved to
// the output register, so the block does not take a new item before it is
// through with the last. A result held in a full output register stalls the
// block until the receiver takes it. The table reads as empty right after
// reset; no clearing pass.
`include "job_slot_table_assert.svh"

module job_slot_table #(
  parameter int unsigned TABLE_ENTRIES = jst_pkg::MAXJOBS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  jst_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output jst_pkg::out_item_t out_item_o
);
  import jst_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic          res_valid;
  logic          res_ready;
  out_item_t     res_item;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          out_valid_q;
  out_item_t     out_item_q;

  jst_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  jst_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `JST_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `JST_ASSERT(a_res_loads_out, clk_i, rst_ni, res_valid && res_ready |=> out_valid_o)
  `JST_ASSERT(a_fail_zero_fields, clk_i, rst_ni,
              out_valid_o && out_item_o.status != ST_OK |->
              out_item_o.found_job_id == '0 && out_item_o.found_proc_id == '0 &&
              out_item_o.found_state == '0)
  `JST_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire

FILE: tb/sv/job_slot_table_tb.sv
`timescale 1ns / 1ps

module job_slot_table_tb;
  import jst_pkg::*;

  localparam int unsigned SLOTS        = MAXJOBS;
  localparam int unsigned N_RANDOM     = 1200;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 80;
  localparam int unsigned DRAIN_AT     = 150;
  localparam int unsigned LATENCY      = 2 * SLOTS + 5;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned MAX_PRINTS   = 50;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [1:0] RUN_BG        = 2'd2;
  localparam logic [1:0] RUN_STOPPED   = 2'd3;

  localparam logic [PROC_BITS-1:0] PROC_MAX = '1;
  localparam logic [JOB_BITS-1:0]  JOB_MAX  = '1;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // predictor copy of the table
  logic [PROC_BITS-1:0] tbl_proc [SLOTS];
  logic [JOB_BITS-1:0]  tbl_job  [SLOTS];
  logic [1:0]           tbl_state[SLOTS];
  logic [JOB_BITS-1:0]  tbl_next_job;

  out_item_t   pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned status_count[4];
  int unsigned quiet_cycles;

  job_slot_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t mk_result(logic [1:0] status, logic [JOB_BITS-1:0] fj,
                                          logic [PROC_BITS-1:0] fp, logic [1:0] fs,
                                          logic [PROC_BITS-1:0] fg);
    out_item_t r;
    r.status          = status;
    r.found_job_id    = fj;
    r.found_proc_id   = fp;
    r.found_state     = fs;
    r.foreground_proc = fg;
    return r;
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_proc[i]  = '0;
      tbl_job[i]   = '0;
      tbl_state[i] = UNDEF;
    end
    tbl_next_job = JOB_BITS'(1);
  endfunction

  // Apply one request to the predictor table and return the result it gives.
  function automatic out_item_t predict_request(in_item_t it);
    out_item_t           r;
    int                  hit;
    logic [JOB_BITS-1:0] top_job;
    r        = '0;
    r.status = ST_NONE;
    hit      = -1;
    if (it.req_type <= REQ_SET_STATE) begin
      if ((it.req_type == REQ_FIND_JOB) ? (it.job_id == '0) : (it.proc_id == '0)) begin
        r.status = ST_BADKEY;
      end else if (it.req_type == REQ_INSERT) begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_proc[i] == '0) hit = i;
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_proc[hit]  = it.proc_id;
          tbl_state[hit] = it.new_state;
          tbl_job[hit]   = tbl_next_job;
          tbl_next_job   = tbl_next_job + 1'b1;
          if (tbl_next_job > SLOTS || tbl_next_job == '0) tbl_next_job = JOB_BITS'(1);
        end
      end else if (it.req_type == REQ_FIND_JOB) begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_job[i] == it.job_id) hit = i;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tbl_proc[i] == it.proc_id) hit = i;
        if (hit >= 0 && it.req_type == REQ_SET_STATE) tbl_state[hit] = it.new_state;
      end
      if (hit >= 0) begin
        r.status        = ST_OK;
        r.found_job_id  = tbl_job[hit];
        r.found_proc_id = tbl_proc[hit];
        r.found_state   = tbl_state[hit];
        if (it.req_type == REQ_DELETE) begin
          tbl_proc[hit]  = '0;
          tbl_job[hit]   = '0;
          tbl_state[hit] = UNDEF;
          top_job = '0;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_job[i] > top_job) top_job = tbl_job[i];
          tbl_next_job = top_job + 1'b1;
          if (tbl_next_job == '0) tbl_next_job = JOB_BITS'(1);
        end
      end
    end
    for (int i = int'(SLOTS) - 1; i >= 0; i--)
      if (tbl_state[i] == FG) r.foreground_proc = tbl_proc[i];
    return r;
  endfunction

  function automatic in_item_t random_request(bit filling);
    in_item_t    it;
    int unsigned pick;
    int unsigned k;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 45 : 15))  it.req_type = REQ_INSERT;
    else if (pick < 55)              it.req_type = REQ_DELETE;
    else if (pick < 67)              it.req_type = REQ_FIND_PROC;
    else if (pick < 79)              it.req_type = REQ_FIND_JOB;
    else if (pick < 96)              it.req_type = REQ_SET_STATE;
    else it.req_type = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    // keep most keys in a small pool so lookups and deletes hit live entries
    k   = $urandom_range(0, 99);
    raw = $urandom;
    if (k < 85)      it.proc_id = PROC_BITS'($urandom_range(1, 20));
    else if (k < 92) it.proc_id = raw[PROC_BITS-1:0];
    else if (k < 96) it.proc_id = PROC_MAX - PROC_BITS'($urandom_range(0, 2));
    else             it.proc_id = '0;
    k   = $urandom_range(0, 99);
    raw = $urandom;
    if (k < 80)      it.job_id = JOB_BITS'($urandom_range(1, 20));
    else if (k < 86) it.job_id = '0;
    else if (k < 94) it.job_id = raw[JOB_BITS-1:0];
    else             it.job_id = JOB_MAX - JOB_BITS'($urandom_range(0, 1));
    it.new_state = 2'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic add_row(logic [2:0] req, logic [PROC_BITS-1:0] pid,
                         logic [JOB_BITS-1:0] jid, logic [1:0] st, bit typed,
                         out_item_t want);
    stim_row_t row;
    row.item.req_type  = req;
    row.item.proc_id   = pid;
    row.item.job_id    = jid;
    row.item.new_state = st;
    row.typed          = typed;
    row.want           = want;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
               results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.found_job_id !== want.found_job_id)
      report_mismatch("found_job_id", 32'(got.found_job_id), 32'(want.found_job_id));
    if (got.found_proc_id !== want.found_proc_id)
      report_mismatch("found_proc_id", 32'(got.found_proc_id), 32'(want.found_proc_id));
    if (got.found_state !== want.found_state)
      report_mismatch("found_state", 32'(got.found_state), 32'(want.found_state));
    if (got.foreground_proc !== want.foreground_proc)
      report_mismatch("foreground_proc", 32'(got.foreground_proc),
                      32'(want.foreground_proc));
  endtask

  // Offer one item, hold it until accepted, then idle or drain as asked.
  task automatic send_request(in_item_t it, bit typed, out_item_t want,
                              int unsigned idle_pct, bit drain);
    out_item_t predicted;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_request(it);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
    if (drain) begin
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk_i);
    end
  endtask

  // receiver: check each result, stall by phase, one long hold-off
  initial begin : receiver
    out_item_t   want;
    int unsigned hold_left;
    bit          held;
    int unsigned mode;
    out_ready_i = 1'b0;
    hold_left   = 0;
    held        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_item_o.status), '0);
        end else begin
          want = pending_results.pop_front();
          compare_result(out_item_o, want);
        end
        status_count[out_item_o.status]++;
        results_seen++;
      end
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      mode = (results_seen / PHASE_ITEMS) % 4;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (mode == 2) begin
        out_ready_i <= ($urandom_range(0, 99) >= 59);
      end else if (mode == 3) begin
        out_ready_i <= ($urandom_range(0, 99) >= 11);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("** job_slot_table: FAILED **");
        $finish;
      end
    end
  end

  initial begin : sender
    in_item_t    it;
    int unsigned mode;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    requests_sent = 0;
    results_seen  = 0;
    mismatches    = 0;
    for (int i = 0; i < 4; i++) status_count[i] = 0;
    table_reset();

    // empty table, zero keys and unused codes
    add_row(REQ_FIND_PROC, 22'd5, 16'd0, UNDEF, 1'b1, mk_result(ST_NONE, '0, '0, '0, '0));
    add_row(REQ_INSERT, '0, 16'd1, FG, 1'b1, mk_result(ST_BADKEY, '0, '0, '0, '0));
    add_row(REQ_FIND_JOB, 22'd5, '0, UNDEF, 1'b1, mk_result(ST_BADKEY, '0, '0, '0, '0));
    add_row(REQ_DELETE, '0, JOB_MAX, RUN_STOPPED, 1'b1,
            mk_result(ST_BADKEY, '0, '0, '0, '0));
    add_row(REQ_SET_STATE, '0, 16'd2, FG, 1'b1, mk_result(ST_BADKEY, '0, '0, '0, '0));
    add_row(REQ_FIND_JOB, PROC_MAX, JOB_MAX, RUN_BG, 1'b1,
            mk_result(ST_NONE, '0, '0, '0, '0));
    add_row(REQ_UNUSED_LO, PROC_MAX, JOB_MAX, RUN_STOPPED, 1'b1,
            mk_result(ST_NONE, '0, '0, '0, '0));
    add_row(REQ_UNUSED_LO + 3'd1, 22'd1, 16'd1, FG, 1'b1,
            mk_result(ST_NONE, '0, '0, '0, '0));
    add_row(REQ_UNUSED_HI, 22'h2aaaaa, 16'h5555, RUN_BG, 1'b1,
            mk_result(ST_NONE, '0, '0, '0, '0));
    // first inserts take job ids 1 and 2
    add_row(REQ_INSERT, PROC_MAX, JOB_MAX, FG, 1'b1,
            mk_result(ST_OK, 16'd1, PROC_MAX, FG, PROC_MAX));
    add_row(REQ_INSERT, 22'd1, '0, RUN_STOPPED, 1'b1,
            mk_result(ST_OK, 16'd2, 22'd1, RUN_STOPPED, PROC_MAX));
    // duplicates, lookups, state changes and deletes
    add_row(REQ_INSERT, 22'd1, 16'd7, RUN_BG, 1'b0, '0);
    add_row(REQ_FIND_PROC, 22'd1, '0, UNDEF, 1'b0, '0);
    add_row(REQ_FIND_JOB, 22'd0, 16'd2, UNDEF, 1'b0, '0);
    add_row(REQ_FIND_JOB, 22'd9, 16'd3, FG, 1'b0, '0);
    add_row(REQ_SET_STATE, 22'd1, 16'd0, FG, 1'b0, '0);
    add_row(REQ_SET_STATE, PROC_MAX, JOB_MAX, RUN_BG, 1'b0, '0);
    add_row(REQ_DELETE, 22'd1, '0, UNDEF, 1'b0, '0);
    add_row(REQ_FIND_PROC, 22'd1, JOB_MAX, RUN_STOPPED, 1'b0, '0);
    add_row(REQ_DELETE, PROC_MAX, 16'd1, FG, 1'b0, '0);
    add_row(REQ_FIND_PROC, 22'h2aaaaa, 16'h5555, RUN_BG, 1'b0, '0);
    add_row(REQ_INSERT, 22'h155555, 16'haaaa, UNDEF, 1'b0, '0);
    add_row(REQ_DELETE, 22'd7, '0, UNDEF, 1'b0, '0);
    add_row(REQ_FIND_JOB, 22'h155555, 16'h5555, RUN_STOPPED, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      send_request(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want,
                   0, 1'b0);

    // alternate fill-heavy and drain-heavy stretches so the table runs full
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = (n / PHASE_ITEMS) % 4;
      it   = random_request(((n / 40) % 2) == 0);
      send_request(it, 1'b0, '0, (mode == 1) ? 59 : ((mode == 3) ? 11 : 0), n == DRAIN_AT);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("ran %0d requests (%0d directed), checked %0d results", requests_sent,
             directed_rows.size(), results_seen);
    $display("statuses: ok %0d, no entry %0d, table full %0d, invalid key %0d",
             status_count[ST_OK], status_count[ST_NONE], status_count[ST_FULL],
             status_count[ST_BADKEY]);
    if (mismatches == 0) begin
      $display("** job_slot_table: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** job_slot_table: FAILED **");
    end
    $finish;
  end

endmodule
